// ----- rtl/core/bda_pkg.sv -----
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types, widths and helpers for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package bda_pkg;

   // Widths of the transaction fields.
   localparam int INPUT_WIDTH = 32;
   localparam int CHAR_WIDTH  = 6;

   // Default width of the binary value taken into account.
   localparam int VALUE_BITS_DEFAULT = 32;

   // Decimal digits of a 32-bit value and the width of one BCD digit.
   localparam int MAX_DIGITS  = 10;
   localparam int DIGIT_WIDTH = 4;

   // ASCII code of the character '0'.
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = CHAR_WIDTH'(48);

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   // Shift-and-add-3 correction of one BCD digit before it is doubled.
   function automatic logic [DIGIT_WIDTH-1:0] digit_adjust(
      input logic [DIGIT_WIDTH-1:0] digit
   );
      logic [DIGIT_WIDTH-1:0] result;
      if (digit >= DIGIT_WIDTH'(5)) begin
         result = digit + DIGIT_WIDTH'(3);
      end else begin
         result = digit;
      end
      return result;
   endfunction

endpackage

// ----- rtl/core/bda_req_if.sv -----
// ----------------------------------------------------------------------------
// bda_req_if
// Input channel: one binary value per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bda_req_if import bda_pkg::*; ();

   logic                   valid;
   logic                   ready;
   logic [INPUT_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);

endinterface

// ----- rtl/core/bda_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bda_rsp_if
// Result channel: one ASCII digit per transaction, with an end-of-run flag.
// ----------------------------------------------------------------------------
interface bda_rsp_if import bda_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] digit_char;
   logic                  last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);

endinterface

// ----- rtl/core/binary_to_decimal_ascii.sv -----
// A value is accepted only in idle, so the next one waits until the last character of
// the previous one has gone into the result register. Between them lie the bit-serial
// conversion of min(VALUE_BITS, 32) bits, the scan that drops up to nine leading zero
// digits, and the emit step, which result stalls hold.
// Reset (synchronous) returns the sequencer to idle and drops the result register; the
// datapath registers are not reset.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned binary value into decimal ASCII text, most significant
// digit first, without leading zeros, one character per result transaction.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii import bda_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   bda_req_if.sink   req,
   bda_rsp_if.source rsp
);

   // Bits actually converted: the input field holds no more than 32.
   localparam int EFF_BITS   = (VALUE_BITS < INPUT_WIDTH) ? VALUE_BITS : INPUT_WIDTH;
   localparam int CNT_WIDTH  = $clog2(EFF_BITS + 1);
   localparam int BCD_WIDTH  = MAX_DIGITS * DIGIT_WIDTH;
   localparam int DCNT_WIDTH = $clog2(MAX_DIGITS + 1);

   state_type               state_ff, state_in;
   logic [EFF_BITS-1:0]     bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]    bcd_ff, bcd_in;
   logic [CNT_WIDTH-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [DCNT_WIDTH-1:0]   dig_cnt_ff, dig_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]   rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [BCD_WIDTH-1:0]    bcd_adjusted;
   logic [DIGIT_WIDTH-1:0]  top_digit;
   logic [BCD_WIDTH-1:0]    bcd_shifted;
   logic                    out_free;

   // Add-3 correction applied to every BCD digit in parallel.
   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         bcd_adjusted[i*DIGIT_WIDTH +: DIGIT_WIDTH] =
            digit_adjust(bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH]);
      end
   end

   // The most significant digit sits at the top of the shifter.
   assign top_digit   = bcd_ff[BCD_WIDTH-1 -: DIGIT_WIDTH];
   assign bcd_shifted = {bcd_ff[BCD_WIDTH-DIGIT_WIDTH-1:0], DIGIT_WIDTH'(0)};
   assign out_free    = !rsp_valid_ff || rsp.ready;

   // Control and datapath state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Sequencer: convert bitwise, drop leading zeros, emit a digit a cycle unless stalled.
   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      req.ready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               bin_in     = req.value[EFF_BITS-1:0];
               bcd_in     = '0;
               bit_cnt_in = CNT_WIDTH'(EFF_BITS);
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            // Shift the next binary bit into the corrected BCD register.
            bcd_in     = {bcd_adjusted[BCD_WIDTH-2:0], bin_ff[EFF_BITS-1]};
            bin_in     = {bin_ff[EFF_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - CNT_WIDTH'(1);
            if (bit_cnt_ff == CNT_WIDTH'(1)) begin
               dig_cnt_in = DCNT_WIDTH'(MAX_DIGITS);
               state_in   = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // Leading zeros are dropped, but the final digit always stays.
            if (top_digit == '0 && dig_cnt_ff > DCNT_WIDTH'(1)) begin
               bcd_in     = bcd_shifted;
               dig_cnt_in = dig_cnt_ff - DCNT_WIDTH'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ASCII_ZERO + CHAR_WIDTH'(top_digit);
               rsp_last_in  = (dig_cnt_ff == DCNT_WIDTH'(1));
               bcd_in       = bcd_shifted;
               dig_cnt_in   = dig_cnt_ff - DCNT_WIDTH'(1);
               if (dig_cnt_ff == DCNT_WIDTH'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register drives the output channel.
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.digit_char = rsp_char_ff;
   assign rsp.last_digit = rsp_last_ff;

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for binary_to_decimal_ascii. A directed table covers
// the extremes and the decimal boundaries, then random values of every
// magnitude follow. Each accepted value queues the digit characters it should
// give, and every result transaction is checked against the oldest of them.
// ----------------------------------------------------------------------------
module testbench import bda_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_BITS    = VALUE_BITS_DEFAULT;
   localparam int RANDOM_VALUES = 240;
   localparam int CALM_FROM     = 200;
   localparam int DRAIN_CYCLES  = 80;

   // One expected character of the decimal text.
   typedef struct {
      logic [CHAR_WIDTH-1:0] digit_char;
      logic                  last_digit;
   } digit_entry_type;

   // One row of the directed table; an empty text means the predictor decides.
   typedef struct {
      logic [INPUT_WIDTH-1:0] value;
      string                  text;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm  = 1'b0;
   int   failures = 0;

   digit_entry_type expected_digits[$];

   directed_row_type directed_rows[$] = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{32'd8,          "8"},
      '{32'd9,          "9"},
      '{32'd10,         "10"},
      '{32'd99,         "99"},
      '{32'd100,        "100"},
      '{32'hFFFF_FFFF,  "4294967295"},
      '{32'd999999999,  "999999999"},
      '{32'd1000000000, "1000000000"},
      '{32'h7FFF_FFFF,  "2147483647"},
      '{32'h8000_0000,  "2147483648"},
      '{32'h5555_5555,  ""},
      '{32'hAAAA_AAAA,  ""},
      '{32'h0000_FFFF,  ""},
      '{32'hFFFF_0000,  ""},
      '{32'd12345,      ""},
      '{32'd1234567890, "1234567890"},
      '{32'd3999999999, ""},
      '{32'd4000000000, "4000000000"},
      '{32'd0,          "0"}
   };

   bda_req_if req_if ();
   bda_rsp_if rsp_if ();

   binary_to_decimal_ascii #(
      .VALUE_BITS (VALUE_BITS)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // Free-running clock, 2 ns period.
   always #1 clock = ~clock;

   // Works out the digit characters of a value, most significant first.
   function automatic void predict_decimal_text(input logic [INPUT_WIDTH-1:0] value);
      logic [INPUT_WIDTH-1:0] remaining;
      logic [DIGIT_WIDTH-1:0] digits[$];
      digit_entry_type        entry;
      remaining = value;
      if (VALUE_BITS < INPUT_WIDTH) begin
         remaining = remaining & ((INPUT_WIDTH'(1) << VALUE_BITS) - INPUT_WIDTH'(1));
      end
      do begin
         digits.push_front(DIGIT_WIDTH'(remaining % 10));
         remaining = remaining / 10;
      end while (remaining != 0);
      foreach (digits[i]) begin
         entry.digit_char = ASCII_ZERO + CHAR_WIDTH'(digits[i]);
         entry.last_digit = (i == digits.size() - 1);
         expected_digits.push_back(entry);
      end
   endfunction

   // Queues the characters typed into the table, or the predicted ones.
   function automatic void queue_decimal_text(
      input logic [INPUT_WIDTH-1:0] value,
      input string                  text
   );
      digit_entry_type entry;
      if (text.len() == 0) begin
         predict_decimal_text(value);
      end else begin
         for (int i = 0; i < text.len(); i++) begin
            entry.digit_char = CHAR_WIDTH'(text[i]);
            entry.last_digit = (i == text.len() - 1);
            expected_digits.push_back(entry);
         end
      end
   endfunction

   // Offers one value, with an optional gap first, and waits for acceptance.
   task automatic send_value(input logic [INPUT_WIDTH-1:0] value, input string text);
      if (!calm && $urandom_range(0, 2) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.value <= value;
      do @(posedge clock); while (!req_if.ready);
      queue_decimal_text(value, text);
   endtask

   // Holds the sender back until every queued character has come out.
   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      while (expected_digits.size() != 0) @(posedge clock);
   endtask

   // Picks a random value: mostly spread over all magnitudes, with a share
   // sitting right at the powers of ten where the digit count changes.
   function automatic logic [INPUT_WIDTH-1:0] random_value();
      logic [INPUT_WIDTH-1:0] power;
      int                     pick;
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
         return $urandom >> $urandom_range(0, 31);
      end else if (pick < 14) begin
         power = 1;
         repeat ($urandom_range(0, 9)) power = power * 10;
         return power + INPUT_WIDTH'($urandom_range(0, 2)) - INPUT_WIDTH'(1);
      end else if (pick == 14) begin
         return '0;
      end
      return $urandom;
   endfunction

   // Reset, then the directed table, then the random values, then the end.
   initial begin
      req_if.valid <= 1'b0;
      req_if.value <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_value(directed_rows[i].value, directed_rows[i].text);
      end
      wait_for_drain();

      for (int n = 0; n < RANDOM_VALUES; n++) begin
         if (n == RANDOM_VALUES / 2) begin
            wait_for_drain();
         end
         calm = (n >= CALM_FROM);
         send_value(random_value(), "");
      end
      req_if.valid <= 1'b0;

      while (expected_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("** binary_to_decimal_ascii: PASSED **");
      end else begin
         $display("** binary_to_decimal_ascii: FAILED **");
      end
      $finish;
   end

   // Receiver back-pressure in bursts; always ready once the run is calm.
   initial begin
      forever begin
         if (calm || reset) begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   // Checks each result transaction against the oldest queued character.
   always @(posedge clock) begin
      digit_entry_type entry;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_digits.size() == 0) begin
            $error("unexpected result: digit_char %0d last_digit %0b",
                   rsp_if.digit_char, rsp_if.last_digit);
            failures++;
         end else begin
            entry = expected_digits.pop_front();
            if (rsp_if.digit_char !== entry.digit_char) begin
               $error("digit_char: expected %0d, got %0d",
                      entry.digit_char, rsp_if.digit_char);
               failures++;
            end
            if (rsp_if.last_digit !== entry.last_digit) begin
               $error("last_digit: expected %0b, got %0b",
                      entry.last_digit, rsp_if.last_digit);
               failures++;
            end
         end
      end
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("** binary_to_decimal_ascii: FAILED **");
      $finish;
   end

endmodule
